FILE: sv/itb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itb_pkg: shared types and constants
// Opcodes, widths and the queue entry passed from front to back end.
// ----------------------------------------------------------------------------
package itb_pkg;
    localparam int TW = 40;
    localparam int AW = 48;
    localparam int DEF_NUM_CHANNELS = 16;
    localparam int DEF_NUM_FRAMES = 1024;
    localparam logic [TW-1:0] FRAME_SIZE_RST = 40'd1000000;
    localparam logic [TW-1:0] TOTAL_DUR_RST = 40'd1000000000;
    localparam logic [AW-1:0] MAX48 = {AW{1'b1}};

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic CFG_FRAME_SIZE = 1'b0;
    localparam logic CFG_TOTAL_DUR = 1'b1;

    localparam logic [1:0] CMD_FLAG = 2'd0;
    localparam logic [1:0] CMD_ADD = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // One classified item as handed to the back end.
    typedef struct packed {
        logic [1:0]    cmd;
        logic [7:0]    chan;
        logic [16:0]   sf;
        logic [16:0]   ef;
        logic [AW-1:0] first_amt;
        logic [AW-1:0] last_amt;
        logic [AW-1:0] mid_amt;
    } cmd_t;
endpackage

FILE: sv/itb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itb_in_if / itb_out_if: valid/ready channels
// Input item channel and result channel of the binning block.
// ----------------------------------------------------------------------------
interface itb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [3:0]  channel;
    logic [39:0] range_start;
    logic [39:0] range_end;
    logic [9:0]  frame_index;
    modport source (output valid, opcode, channel, range_start, range_end, frame_index,
                    input ready);
    modport sink (input valid, opcode, channel, range_start, range_end, frame_index,
                  output ready);
endinterface

interface itb_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] frame_total;
    logic        status;
    modport source (output valid, frame_total, status, input ready);
    modport sink (input valid, frame_total, status, output ready);
endinterface

FILE: sv/itb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itb_div: iterative 40-bit divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itb_div
    import itb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [TW-1:0] dividend,
    input  logic [TW-1:0] divisor,
    output logic          done,
    output logic [TW-1:0] quotient,
    output logic [TW-1:0] remainder
);
    logic [TW-1:0] q_reg;
    logic [TW-1:0] r_reg;
    logic [TW-1:0] d_reg;
    logic [5:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [TW:0]   shifted;
    logic [TW:0]   diff;

    assign shifted = {r_reg, q_reg[TW-1]};
    assign diff = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'(TW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The partial remainder stays below the divisor, so it fits in TW bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[TW])
            begin
                r_reg <= diff[TW-1:0];
                q_reg <= {q_reg[TW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted[TW-1:0];
                q_reg <= {q_reg[TW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quotient = q_reg;
    assign remainder = r_reg;
endmodule

FILE: sv/itb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itb_front: item classifier
// Divides the range ends and the total duration by the frame size, checks
// bounds and builds a command for the back end.
// ----------------------------------------------------------------------------
module itb_front
    import itb_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int NUM_FRAMES = DEF_NUM_FRAMES
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [TW-1:0] frame_len,
    input  logic [TW-1:0] total_duration,
    itb_in_if.sink        in_ch,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output cmd_t          cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV0 = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_DIV2 = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;

    logic [2:0]    state_reg;
    logic [1:0]    op_reg;
    logic [3:0]    ch_reg;
    logic [TW-1:0] rs_reg;
    logic [TW-1:0] re_reg;
    logic [9:0]    fi_reg;
    logic [TW-1:0] sf_reg;
    logic [TW-1:0] ef_reg;
    logic [TW-1:0] last_reg;
    logic [TW-1:0] rs_rem_reg;
    logic [TW-1:0] re_rem_reg;
    cmd_t          cmd_reg;

    logic          div_start;
    logic [TW-1:0] div_dividend;
    logic          div_done;
    logic [TW-1:0] div_q;
    logic [TW-1:0] div_r;
    logic          need_div;

    itb_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
        .divisor(frame_len), .done(div_done), .quotient(div_q), .remainder(div_r)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    // Only adds and reads with a nonzero frame size need the divisions.
    assign need_div = (frame_len != '0)
                      && (in_ch.opcode == OP_ADD || in_ch.opcode == OP_READ);
    assign div_start = (in_ch.valid && in_ch.ready && need_div)
                       || (div_done && (state_reg == S_DIV0 || state_reg == S_DIV1));
    always_comb
    begin
        case (state_reg)
            S_IDLE: div_dividend = in_ch.range_start;
            S_DIV0: div_dividend = re_reg;
            default: div_dividend = total_duration;
        endcase
    end

    // Number of valid frames bounded by NUM_FRAMES.
    logic [16:0] nvalid;
    logic        ch_bad;
    logic        ef_bad;
    logic        fi_bad;
    logic [AW-1:0] fs48;
    always_comb
    begin
        nvalid = (last_reg >= TW'(NUM_FRAMES)) ? 17'(NUM_FRAMES) : 17'(last_reg + 1'b1);
        ch_bad = (32'(ch_reg) >= NUM_CHANNELS);
        ef_bad = (ef_reg >= TW'(nvalid));
        fi_bad = (17'(fi_reg) >= nvalid);
        fs48 = AW'(frame_len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        if (need_div)
                            state_reg <= S_DIV0;
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_DIV0: if (div_done) state_reg <= S_DIV1;
                S_DIV1: if (div_done) state_reg <= S_DIV2;
                S_DIV2: if (div_done) state_reg <= S_CHECK;
                S_CHECK: state_reg <= S_OUT;
                S_OUT: if (cmd_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            op_reg <= in_ch.opcode;
            ch_reg <= in_ch.channel;
            rs_reg <= in_ch.range_start;
            re_reg <= in_ch.range_end;
            fi_reg <= in_ch.frame_index;
            cmd_reg.cmd <= (in_ch.opcode == OP_CLEAR) ? CMD_CLEAR : CMD_FLAG;
        end
        if (div_done)
        begin
            case (state_reg)
                S_DIV0:
                begin
                    sf_reg <= div_q;
                    rs_rem_reg <= div_r;
                end
                S_DIV1:
                begin
                    ef_reg <= div_q;
                    re_rem_reg <= div_r;
                end
                default: last_reg <= div_q;
            endcase
        end
        if (state_reg == S_CHECK)
        begin
            cmd_reg.chan <= 8'(ch_reg);
            cmd_reg.ef <= 17'(ef_reg);
            cmd_reg.mid_amt <= fs48;
            if (op_reg == OP_READ)
            begin
                cmd_reg.cmd <= (ch_bad || fi_bad) ? CMD_FLAG : CMD_READ;
                cmd_reg.sf <= 17'(fi_reg);
            end
            else
            begin
                cmd_reg.cmd <= (ch_bad || re_reg < rs_reg || ef_bad) ? CMD_FLAG : CMD_ADD;
                cmd_reg.sf <= 17'(sf_reg);
                // Start frame: rest after start offset; whole range if sf == ef.
                if (sf_reg == ef_reg)
                    cmd_reg.first_amt <= AW'(re_reg - rs_reg) + 1'b1;
                else
                    cmd_reg.first_amt <= fs48 - AW'(rs_rem_reg);
                cmd_reg.last_amt <= AW'(re_rem_reg) + 1'b1;
            end
        end
    end

    assign cmd_valid = (state_reg == S_OUT);
    assign cmd = cmd_reg;
endmodule

FILE: sv/itb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itb_fifo: command queue
// Two-entry queue between the classifier and the store sequencer.
// ----------------------------------------------------------------------------
module itb_fifo
    import itb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_data
);
    cmd_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= wr_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop) else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count did not advance");
endmodule

FILE: sv/itb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itb_back: store sequencer
// Walks the spanned frames with read-modify-write on the totals memory,
// serves reads and clears. Entries carry an epoch mark so a clear only
// advances the epoch; on epoch wraparound the memory is swept.
// ----------------------------------------------------------------------------
module itb_back
    import itb_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int NUM_FRAMES = DEF_NUM_FRAMES
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  cmd_t     cmd,
    itb_out_if.source out_ch
);
    localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    // The address is the channel above the frame, so each field gets its own bits.
    localparam int IW = CHW + FW;
    localparam int DEPTH = 1 << IW;
    localparam int EW = 4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD = 3'd1;
    localparam logic [2:0] S_WR = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;

    logic [EW+AW-1:0] mem [DEPTH];
    logic [EW+AW-1:0] rdata_reg;

    logic [2:0]    state_reg;
    logic [16:0]   f_reg;
    logic [16:0]   ef_reg;
    logic [16:0]   sf_reg;
    logic [CHW-1:0] ch_reg;
    logic          is_read_reg;
    logic [AW-1:0] first_reg;
    logic [AW-1:0] last_reg;
    logic [AW-1:0] mid_reg;
    logic [EW-1:0] epoch_reg;
    logic [IW:0]   sweep_reg;
    logic          res_valid_reg;
    logic [AW-1:0] res_total_reg;
    logic          res_status_reg;
    logic          restart_reg;

    logic [IW-1:0] addr;
    logic [AW-1:0] cur;
    logic [AW-1:0] amt;
    logic [AW:0]   sum;

    assign addr = IW'({ch_reg, f_reg[FW-1:0]});
    assign cur = (rdata_reg[EW+AW-1:AW] == epoch_reg) ? rdata_reg[AW-1:0] : '0;
    assign amt = (f_reg == sf_reg) ? first_reg : ((f_reg == ef_reg) ? last_reg : mid_reg);
    assign sum = {1'b0, cur} + {1'b0, amt};

    assign cmd_ready = (state_reg == S_IDLE) && !res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            sweep_reg <= '0;
            epoch_reg <= '0;
            res_valid_reg <= 1'b0;
            restart_reg <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready) res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && cmd_ready)
                    begin
                        case (cmd.cmd)
                            CMD_ADD, CMD_READ: state_reg <= S_RD;
                            CMD_CLEAR:
                            begin
                                epoch_reg <= epoch_reg + 1'b1;
                                if (epoch_reg == {EW{1'b1}})
                                begin
                                    state_reg <= S_SWEEP;
                                    sweep_reg <= '0;
                                    restart_reg <= 1'b1;
                                end
                                else
                                    res_valid_reg <= 1'b1;
                            end
                            default: res_valid_reg <= 1'b1;
                        endcase
                    end
                end
                S_RD: state_reg <= S_WR;
                S_WR:
                begin
                    if (is_read_reg || f_reg == ef_reg)
                    begin
                        state_reg <= S_IDLE;
                        res_valid_reg <= 1'b1;
                    end
                    else
                        state_reg <= S_RD;
                end
                S_SWEEP:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == (IW+1)'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                        if (restart_reg) res_valid_reg <= 1'b1;
                        restart_reg <= 1'b0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid && cmd_ready)
        begin
            ch_reg <= CHW'(cmd.chan);
            f_reg <= cmd.sf;
            sf_reg <= cmd.sf;
            ef_reg <= cmd.ef;
            first_reg <= cmd.first_amt;
            last_reg <= cmd.last_amt;
            mid_reg <= cmd.mid_amt;
            is_read_reg <= (cmd.cmd == CMD_READ);
            res_total_reg <= '0;
            res_status_reg <= (cmd.cmd == CMD_FLAG);
        end
        if (state_reg == S_RD)
            rdata_reg <= mem[addr];
        if (state_reg == S_WR)
        begin
            if (is_read_reg)
                res_total_reg <= cur;
            else
            begin
                mem[addr] <= {epoch_reg, (sum[AW] ? MAX48 : sum[AW-1:0])};
                f_reg <= f_reg + 1'b1;
            end
        end
        if (state_reg == S_SWEEP)
            mem[sweep_reg[IW-1:0]] <= {epoch_reg + 1'b1, {AW{1'b0}}};
    end

    assign out_ch.valid = res_valid_reg;
    assign out_ch.frame_total = res_total_reg;
    assign out_ch.status = res_status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status) |-> out_ch.frame_total == '0)
        else $error("flagged result carries a total");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> !res_valid_reg) else $error("command taken while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR && !is_read_reg) |-> f_reg <= ef_reg)
        else $error("frame walk overran the end frame");
endmodule

FILE: sv/interval_time_binning.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_time_binning: per-channel idle time histogram
// Adds inclusive nanosecond ranges into per-frame totals, serves reads and
// clears.
// ----------------------------------------------------------------------------
// Port      Kind    Contents
// in_ch     sink    opcode, channel, range_start, range_end, frame_index
// out_ch    source  frame_total, status
// cfg_*     write   frame length (0), total duration (1)
//
// The classifier runs three serial divisions per add or read when the frame
// size is nonzero; the sequencer reads and writes back each spanned frame.
// Clear and flagged items skip the frame walk. After reset and after every
// sixteenth clear a sweep writes each store entry (16384 at the default
// sizes) to clear the store; no item is accepted by the store during it.
// Either side may stall freely.
// ----------------------------------------------------------------------------
module interval_time_binning
    import itb_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int NUM_FRAMES = DEF_NUM_FRAMES
)
(
    input  logic          clk,
    input  logic          rst_n,
    itb_in_if.sink        in_ch,
    itb_out_if.source     out_ch,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [TW-1:0] cfg_data
);
    logic [TW-1:0] frame_len_reg;
    logic [TW-1:0] total_dur_reg;
    logic          f_valid;
    logic          f_ready;
    cmd_t          f_cmd;
    logic          b_valid;
    logic          b_ready;
    cmd_t          b_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_len_reg <= FRAME_SIZE_RST;
            total_dur_reg <= TOTAL_DUR_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FRAME_SIZE)
                frame_len_reg <= cfg_data;
            else
                total_dur_reg <= cfg_data;
        end
    end

    itb_front #(.NUM_CHANNELS(NUM_CHANNELS), .NUM_FRAMES(NUM_FRAMES)) u_front (
        .clk(clk), .rst_n(rst_n), .frame_len(frame_len_reg),
        .total_duration(total_dur_reg), .in_ch(in_ch),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    itb_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready),
        .wr_data(f_cmd), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
    );

    itb_back #(.NUM_CHANNELS(NUM_CHANNELS), .NUM_FRAMES(NUM_FRAMES)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(b_valid), .cmd_ready(b_ready),
        .cmd(b_cmd), .out_ch(out_ch)
    );
endmodule
